>>> rtl/core/slsm_pkg.sv
`timescale 1ns / 1ps

package slsm_pkg;

  // Operation codes carried by the operation field
  typedef enum logic [1:0] {
    OP_APPEND_FIRST  = 2'd0,
    OP_APPEND_SECOND = 2'd1,
    OP_DELETE        = 2'd2,
    OP_MERGE         = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_EMPTY = 2'd3
  } status_e;

  localparam int unsigned IN_WORD_W  = 32;
  localparam int unsigned OUT_WORD_W = 32;
  localparam int unsigned POS_W      = 6;

endpackage

>>> rtl/core/slsm_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port, registered read data.
module slsm_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/sorted_list_store_merge.sv
`timescale 1ns / 1ps

// Two bounded lists of signed words, each stored in its own single-read-port RAM.
// A transaction appends a word to either list, deletes the word at a 1-based
// position of the first list (later words move down by one), or merges both
// lists, taken as ascending, into one ordered run with first-list words ahead on
// ties; the merge leaves the lists as they are and marks its final word with
// last. Every transaction yields at least one result; a merge yields one per
// stored word. One transaction is in flight at a time; the next is taken once
// the current one has handed its final result to the output register, and that
// register may still hold it. A delete moves each later word down one slot before its
// result; a merge hands out one word a cycle while the output is not stalled (set
// by the single read port of each RAM feeding the compare). No clearing pass is
// needed: words past the fill counts are never read.
module sorted_list_store_merge #(
  parameter int unsigned LIST_DEPTH = 32,
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  output logic                                       in_stall_o,
  input  logic [1:0]                                 operation_i,
  input  logic signed [slsm_pkg::IN_WORD_W-1:0]      value_i,
  input  logic [slsm_pkg::POS_W-1:0]                 position_i,
  output logic                                       out_valid_o,
  input  logic                                       out_stall_i,
  output logic signed [slsm_pkg::OUT_WORD_W-1:0]     merged_value_o,
  output logic                                       last_o,
  output logic [1:0]                                 status_o
);

  localparam int unsigned AW = $clog2(LIST_DEPTH);
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned PW = (CW > slsm_pkg::POS_W) ? CW + 1 : slsm_pkg::POS_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DEL_SHIFT,
    ST_DEL_DONE,
    ST_MERGE
  } state_e;

  state_e                         state_q, state_d;
  slsm_pkg::op_e                  op_q, op_d;
  logic [WORD_WIDTH-1:0]          val_q, val_d;
  logic [slsm_pkg::POS_W-1:0]     pos_q, pos_d;
  logic [CW-1:0]                  ia_q, ia_d;
  logic [CW-1:0]                  ib_q, ib_d;
  logic [CW-1:0]                  cnt_a_q, cnt_a_d;
  logic [CW-1:0]                  cnt_b_q, cnt_b_d;

  logic                           out_valid_q, out_valid_d;
  logic [slsm_pkg::OUT_WORD_W-1:0] out_value_q, out_value_d;
  logic                           out_last_q, out_last_d;
  slsm_pkg::status_e              out_status_q, out_status_d;

  logic                           we_a, we_b;
  logic [AW-1:0]                  waddr_a, waddr_b;
  logic [WORD_WIDTH-1:0]          wdata_a, wdata_b;
  logic [AW-1:0]                  raddr_a, raddr_b;
  logic [WORD_WIDTH-1:0]          rdata_a, rdata_b;

  logic                           out_free;
  logic                           full_a, full_b;
  logic [PW-1:0]                  pos_ext, cnt_a_ext;
  logic                           pos_bad;
  logic [CW:0]                    total, taken_next;
  logic                           take_a;
  logic [WORD_WIDTH-1:0]          merge_word;
  logic [CW-1:0]                  ia_rd;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign full_a    = (cnt_a_q == CW'(LIST_DEPTH));
  assign full_b    = (cnt_b_q == CW'(LIST_DEPTH));
  assign pos_ext   = PW'(pos_q);
  assign cnt_a_ext = PW'(cnt_a_q);
  assign pos_bad   = (pos_q == '0) || (pos_ext > cnt_a_ext);
  assign total     = {1'b0, cnt_a_q} + {1'b0, cnt_b_q};
  assign taken_next = {1'b0, ia_q} + {1'b0, ib_q} + (CW + 1)'(1);

  // Take the first-list head while it lasts and is not above the second-list head
  assign take_a = (ia_q < cnt_a_q) &&
                  ((ib_q >= cnt_b_q) || ($signed(rdata_a) <= $signed(rdata_b)));
  assign merge_word = take_a ? rdata_a : rdata_b;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    val_d        = val_q;
    pos_d        = pos_q;
    ia_d         = ia_q;
    ib_d         = ib_q;
    cnt_a_d      = cnt_a_q;
    cnt_b_d      = cnt_b_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_value_d  = out_value_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;
    we_a         = 1'b0;
    we_b         = 1'b0;
    waddr_a      = cnt_a_q[AW-1:0];
    waddr_b      = cnt_b_q[AW-1:0];
    wdata_a      = val_q;
    wdata_b      = val_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = slsm_pkg::op_e'(operation_i);
          val_d   = WORD_WIDTH'(value_i);
          pos_d   = position_i;
          state_d = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        unique case (op_q)
          slsm_pkg::OP_APPEND_FIRST: begin
            if (out_free) begin
              out_valid_d  = 1'b1;
              out_value_d  = '0;
              out_last_d   = 1'b1;
              out_status_d = full_a ? slsm_pkg::STATUS_FULL : slsm_pkg::STATUS_OK;
              if (!full_a) begin
                we_a    = 1'b1;
                cnt_a_d = cnt_a_q + CW'(1);
              end
              state_d = ST_IDLE;
            end
          end
          slsm_pkg::OP_APPEND_SECOND: begin
            if (out_free) begin
              out_valid_d  = 1'b1;
              out_value_d  = '0;
              out_last_d   = 1'b1;
              out_status_d = full_b ? slsm_pkg::STATUS_FULL : slsm_pkg::STATUS_OK;
              if (!full_b) begin
                we_b    = 1'b1;
                cnt_b_d = cnt_b_q + CW'(1);
              end
              state_d = ST_IDLE;
            end
          end
          slsm_pkg::OP_DELETE: begin
            if (pos_bad) begin
              if (out_free) begin
                out_valid_d  = 1'b1;
                out_value_d  = '0;
                out_last_d   = 1'b1;
                out_status_d = slsm_pkg::STATUS_RANGE;
                state_d      = ST_IDLE;
              end
            end else begin
              // Start the shift at the deleted slot; deleting the tail needs no shift
              ia_d    = CW'(pos_q - slsm_pkg::POS_W'(1));
              state_d = (pos_ext < cnt_a_ext) ? ST_DEL_SHIFT : ST_DEL_DONE;
            end
          end
          slsm_pkg::OP_MERGE: begin
            if (total == '0) begin
              if (out_free) begin
                out_valid_d  = 1'b1;
                out_value_d  = '0;
                out_last_d   = 1'b1;
                out_status_d = slsm_pkg::STATUS_EMPTY;
                state_d      = ST_IDLE;
              end
            end else begin
              ia_d    = '0;
              ib_d    = '0;
              state_d = ST_MERGE;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end

      ST_DEL_SHIFT: begin
        // Read data holds entry ia+1; move it down one slot
        we_a    = 1'b1;
        waddr_a = ia_q[AW-1:0];
        wdata_a = rdata_a;
        ia_d    = ia_q + CW'(1);
        if (({1'b0, ia_q} + (CW + 1)'(2)) >= {1'b0, cnt_a_q}) begin
          state_d = ST_DEL_DONE;
        end
      end

      ST_DEL_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = '0;
          out_last_d   = 1'b1;
          out_status_d = slsm_pkg::STATUS_OK;
          cnt_a_d      = cnt_a_q - CW'(1);
          state_d      = ST_IDLE;
        end
      end

      ST_MERGE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = slsm_pkg::OUT_WORD_W'(merge_word);
          out_last_d   = (taken_next == total);
          out_status_d = slsm_pkg::STATUS_OK;
          if (take_a) begin
            ia_d = ia_q + CW'(1);
          end else begin
            ib_d = ib_q + CW'(1);
          end
          if (taken_next == total) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Address the RAMs from the next index so the registered read data lines up with it:
  // delete reads one slot ahead of the write, merge reads the list heads
  assign ia_rd   = (op_q == slsm_pkg::OP_DELETE) ? (ia_d + CW'(1)) : ia_d;
  assign raddr_a = ia_rd[AW-1:0];
  assign raddr_b = ib_d[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_q         <= slsm_pkg::OP_APPEND_FIRST;
      ia_q         <= '0;
      ib_q         <= '0;
      cnt_a_q      <= '0;
      cnt_b_q      <= '0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
      out_status_q <= slsm_pkg::STATUS_OK;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      ia_q         <= ia_d;
      ib_q         <= ib_d;
      cnt_a_q      <= cnt_a_d;
      cnt_b_q      <= cnt_b_d;
      out_valid_q  <= out_valid_d;
      out_last_q   <= out_last_d;
      out_status_q <= out_status_d;
    end
  end

  // Payload holding registers
  always_ff @(posedge clk_i) begin
    val_q       <= val_d;
    pos_q       <= pos_d;
    out_value_q <= out_value_d;
  end

  slsm_ram #(
    .DEPTH (LIST_DEPTH),
    .WIDTH (WORD_WIDTH)
  ) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr_a),
    .wdata_i (wdata_a),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  slsm_ram #(
    .DEPTH (LIST_DEPTH),
    .WIDTH (WORD_WIDTH)
  ) u_second_ram (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr_b),
    .wdata_i (wdata_b),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  assign out_valid_o    = out_valid_q;
  assign merged_value_o = out_value_q;
  assign last_o         = out_last_q;
  assign status_o       = out_status_q;

  // Fill counts stay within the list depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_a_q <= CW'(LIST_DEPTH)) && (cnt_b_q <= CW'(LIST_DEPTH)))
    else $error("list fill count above depth");

  // A merge never walks past the words it owns
  a_merge_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE) |-> (({1'b0, ia_q} + {1'b0, ib_q}) < total))
    else $error("merge index past stored words");

  // An accepted transaction holds off the next one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second transaction taken while one is in flight");

  // Only merged words carry a nonzero value
  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != slsm_pkg::STATUS_OK || out_last_q) &&
     (out_status_q != slsm_pkg::STATUS_OK)) |-> (out_value_q == '0))
    else $error("nonzero value on a status result");

endmodule

>>> verif/sorted_list_store_merge_tb.sv
`timescale 1ns / 1ps

module sorted_list_store_merge_tb;

  localparam int unsigned LIST_DEPTH = 32;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned PHASE_ITEMS = 120;

  // One result transaction as the block should present it
  typedef struct {
    logic signed [slsm_pkg::OUT_WORD_W-1:0] merged_value;
    logic                                   last;
    slsm_pkg::status_e                      status;
  } list_result_t;

  // One row of the directed stimulus; reps repeats the row with value + rep,
  // and typed rows carry their single result status written out by hand
  typedef struct {
    slsm_pkg::op_e                  op;
    logic [slsm_pkg::IN_WORD_W-1:0] value;
    logic [slsm_pkg::POS_W-1:0]     pos;
    int unsigned                    reps;
    bit                             typed;
    slsm_pkg::status_e              status;
  } stim_row_t;

  logic                                   clk_i = 1'b0;
  logic                                   rst_ni = 1'b0;
  logic                                   in_valid_i = 1'b0;
  logic                                   in_stall_o;
  logic [1:0]                             operation_i = slsm_pkg::OP_APPEND_FIRST;
  logic signed [slsm_pkg::IN_WORD_W-1:0]  value_i = '0;
  logic [slsm_pkg::POS_W-1:0]             position_i = '0;
  logic                                   out_valid_o;
  logic                                   out_stall_i = 1'b0;
  logic signed [slsm_pkg::OUT_WORD_W-1:0] merged_value_o;
  logic                                   last_o;
  logic [1:0]                             status_o;

  // Shadow copy of both lists, updated when an input transaction is accepted
  logic signed [WORD_W-1:0] shadow_first  [LIST_DEPTH];
  logic signed [WORD_W-1:0] shadow_second [LIST_DEPTH];
  int unsigned              shadow_first_cnt  = 0;
  int unsigned              shadow_second_cnt = 0;

  list_result_t pending_results [$];
  stim_row_t    directed_rows [26];

  int          fail_count        = 0;
  int unsigned sent_items        = 0;
  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_idle_pct = 0;

  sorted_list_store_merge #(
    .LIST_DEPTH (LIST_DEPTH),
    .WORD_WIDTH (WORD_W)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .value_i        (value_i),
    .position_i     (position_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .merged_value_o (merged_value_o),
    .last_o         (last_o),
    .status_o       (status_o)
  );

  always #5 clk_i = ~clk_i;

  // Work out the results of one accepted transaction and queue them in order
  task automatic predict_list_op(input slsm_pkg::op_e op,
                                 input logic signed [WORD_W-1:0] value,
                                 input logic [slsm_pkg::POS_W-1:0] pos);
    list_result_t r;
    int unsigned  ia;
    int unsigned  ib;
    int unsigned  total;
    int unsigned  k;
    r.merged_value = '0;
    r.last         = 1'b1;
    r.status       = slsm_pkg::STATUS_OK;
    case (op)
      slsm_pkg::OP_APPEND_FIRST: begin
        if (shadow_first_cnt >= LIST_DEPTH) begin
          r.status = slsm_pkg::STATUS_FULL;
        end else begin
          shadow_first[shadow_first_cnt] = value;
          shadow_first_cnt++;
        end
        pending_results.push_back(r);
      end
      slsm_pkg::OP_APPEND_SECOND: begin
        if (shadow_second_cnt >= LIST_DEPTH) begin
          r.status = slsm_pkg::STATUS_FULL;
        end else begin
          shadow_second[shadow_second_cnt] = value;
          shadow_second_cnt++;
        end
        pending_results.push_back(r);
      end
      slsm_pkg::OP_DELETE: begin
        if (pos == 0 || pos > shadow_first_cnt) begin
          r.status = slsm_pkg::STATUS_RANGE;
        end else begin
          // Shift the later words down over the deleted slot
          for (k = pos - 1; k + 1 < shadow_first_cnt; k++) shadow_first[k] = shadow_first[k + 1];
          shadow_first_cnt--;
        end
        pending_results.push_back(r);
      end
      slsm_pkg::OP_MERGE: begin
        total = shadow_first_cnt + shadow_second_cnt;
        if (total == 0) begin
          r.status = slsm_pkg::STATUS_EMPTY;
          pending_results.push_back(r);
        end else begin
          ia = 0;
          ib = 0;
          for (k = 0; k < total; k++) begin
            // Take the first list on equal heads
            if (ib >= shadow_second_cnt ||
                (ia < shadow_first_cnt && shadow_first[ia] <= shadow_second[ib])) begin
              r.merged_value = shadow_first[ia];
              ia++;
            end else begin
              r.merged_value = shadow_second[ib];
              ib++;
            end
            r.last = (k == total - 1);
            pending_results.push_back(r);
          end
        end
      end
    endcase
  endtask

  // Present one input transaction after a random gap and hold it until accepted
  task automatic send_op(input slsm_pkg::op_e op, input logic [slsm_pkg::IN_WORD_W-1:0] value,
                         input logic [slsm_pkg::POS_W-1:0] pos);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    value_i     <= value;
    position_i  <= pos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_items++;
    predict_list_op(op, value, pos);
  endtask

  // Hold off the sender until every queued result has been taken
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Append n words that keep the chosen list ascending; the first list now and
  // then copies a word of the second list to force ties in the merge
  task automatic append_run(input bit to_second, input int unsigned n);
    longint      nxt;
    int unsigned i;
    int unsigned j;
    for (i = 0; i < n; i++) begin
      if (to_second) begin
        if (shadow_second_cnt == 0) nxt = longint'(int'($urandom)) >>> 1;
        else nxt = longint'(shadow_second[shadow_second_cnt - 1]);
      end else begin
        if (shadow_first_cnt == 0) nxt = longint'(int'($urandom)) >>> 1;
        else nxt = longint'(shadow_first[shadow_first_cnt - 1]);
      end
      if ((to_second ? shadow_second_cnt : shadow_first_cnt) != 0 && $urandom_range(7) != 0)
        nxt += $urandom_range(1 << 24);
      if (nxt > 64'sd2147483647) nxt = 64'sd2147483647;
      if (!to_second && shadow_second_cnt != 0 && $urandom_range(3) == 0) begin
        j = $urandom_range(shadow_second_cnt - 1);
        if (shadow_first_cnt == 0 ||
            shadow_second[j] >= shadow_first[shadow_first_cnt - 1])
          nxt = longint'(shadow_second[j]);
      end
      send_op(to_second ? slsm_pkg::OP_APPEND_SECOND : slsm_pkg::OP_APPEND_FIRST,
              nxt[WORD_W-1:0], slsm_pkg::POS_W'($urandom_range(63)));
    end
  endtask

  // Delete a word at a valid position, mostly the head or the tail
  task automatic delete_valid();
    logic [slsm_pkg::POS_W-1:0] pos;
    case ($urandom_range(2))
      0:       pos = slsm_pkg::POS_W'(1);
      1:       pos = slsm_pkg::POS_W'(shadow_first_cnt);
      default: pos = slsm_pkg::POS_W'($urandom_range(1, shadow_first_cnt));
    endcase
    send_op(slsm_pkg::OP_DELETE, $urandom, pos);
  endtask

  // Check each result transaction against the oldest queued expectation, then
  // pick the stall for the next cycle
  always @(posedge clk_i) begin : result_checker
    list_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: merged_value %0d last %0b status %0d",
               merged_value_o, last_o, status_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (merged_value_o !== want.merged_value) begin
          $error("merged_value: expected %0d, got %0d", want.merged_value, merged_value_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          fail_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < receiver_idle_pct);
  end

  initial begin
    int unsigned  n;
    int unsigned  rep;
    int unsigned  phase;
    int unsigned  phase_start;
    int unsigned  pick;
    int unsigned  guard;
    list_result_t typed_r;

    directed_rows = '{
      // Empty store: delete is out of range, merge flags empty
      '{slsm_pkg::OP_DELETE,        32'h1234_5678, 6'd1,  1,  1'b1, slsm_pkg::STATUS_RANGE},
      '{slsm_pkg::OP_MERGE,         32'hFFFF_FFFF, 6'd63, 1,  1'b1, slsm_pkg::STATUS_EMPTY},
      // Extreme words in both lists, tied across the lists
      '{slsm_pkg::OP_APPEND_FIRST,  32'h8000_0000, 6'd0,  1,  1'b1, slsm_pkg::STATUS_OK},
      '{slsm_pkg::OP_APPEND_FIRST,  32'h7FFF_FFFF, 6'd0,  1,  1'b1, slsm_pkg::STATUS_OK},
      '{slsm_pkg::OP_APPEND_SECOND, 32'h8000_0000, 6'd63, 1,  1'b1, slsm_pkg::STATUS_OK},
      '{slsm_pkg::OP_APPEND_SECOND, 32'h7FFF_FFFF, 6'd0,  1,  1'b1, slsm_pkg::STATUS_OK},
      '{slsm_pkg::OP_MERGE,         32'h0000_0000, 6'd0,  1,  1'b0, slsm_pkg::STATUS_OK},
      // Positions zero, one past the count and the top of the field
      '{slsm_pkg::OP_DELETE,        32'hFFFF_FFFF, 6'd0,  1,  1'b1, slsm_pkg::STATUS_RANGE},
      '{slsm_pkg::OP_DELETE,        32'h0000_0000, 6'd3,  1,  1'b1, slsm_pkg::STATUS_RANGE},
      '{slsm_pkg::OP_DELETE,        32'h0000_0000, 6'd63, 1,  1'b1, slsm_pkg::STATUS_RANGE},
      '{slsm_pkg::OP_DELETE,        32'h0000_0000, 6'd2,  1,  1'b1, slsm_pkg::STATUS_OK},
      '{slsm_pkg::OP_DELETE,        32'h0000_0000, 6'd1,  1,  1'b1, slsm_pkg::STATUS_OK},
      '{slsm_pkg::OP_MERGE,         32'h0000_0000, 6'd0,  1,  1'b0, slsm_pkg::STATUS_OK},
      '{slsm_pkg::OP_APPEND_FIRST,  32'hFFFF_FFFB, 6'd0,  1,  1'b1, slsm_pkg::STATUS_OK},
      '{slsm_pkg::OP_APPEND_FIRST,  32'h0000_0000, 6'd0,  1,  1'b1, slsm_pkg::STATUS_OK},
      '{slsm_pkg::OP_APPEND_FIRST,  32'h0000_0005, 6'd0,  1,  1'b1, slsm_pkg::STATUS_OK},
      '{slsm_pkg::OP_MERGE,         32'h0000_0000, 6'd0,  1,  1'b0, slsm_pkg::STATUS_OK},
      '{slsm_pkg::OP_DELETE,        32'h0000_0000, 6'd2,  1,  1'b1, slsm_pkg::STATUS_OK},
      // Fill both lists to capacity, then overflow each
      '{slsm_pkg::OP_APPEND_FIRST,  32'd100,       6'd0,  30, 1'b1, slsm_pkg::STATUS_OK},
      '{slsm_pkg::OP_APPEND_FIRST,  32'd1,         6'd0,  1,  1'b1, slsm_pkg::STATUS_FULL},
      '{slsm_pkg::OP_APPEND_SECOND, 32'd200,       6'd0,  30, 1'b1, slsm_pkg::STATUS_OK},
      '{slsm_pkg::OP_APPEND_SECOND, 32'd0,         6'd0,  1,  1'b1, slsm_pkg::STATUS_FULL},
      '{slsm_pkg::OP_MERGE,         32'h0000_0000, 6'd0,  1,  1'b0, slsm_pkg::STATUS_OK},
      // Delete the very last word, then one past the shortened count
      '{slsm_pkg::OP_DELETE,        32'h0000_0000, 6'd32, 1,  1'b1, slsm_pkg::STATUS_OK},
      '{slsm_pkg::OP_DELETE,        32'h0000_0000, 6'd32, 1,  1'b1, slsm_pkg::STATUS_RANGE},
      '{slsm_pkg::OP_MERGE,         32'h0000_0000, 6'd0,  1,  1'b0, slsm_pkg::STATUS_OK}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, sender idling less than the receiver
    sender_idle_pct   = 28;
    receiver_idle_pct = 56;
    foreach (directed_rows[row]) begin
      for (rep = 0; rep < directed_rows[row].reps; rep++) begin
        send_op(directed_rows[row].op, directed_rows[row].value + rep,
                directed_rows[row].pos);
        if (directed_rows[row].typed) begin
          // Replace the predicted single result with the hand-written one
          void'(pending_results.pop_back());
          typed_r.merged_value = '0;
          typed_r.last         = 1'b1;
          typed_r.status       = directed_rows[row].status;
          pending_results.push_back(typed_r);
        end
      end
    end
    wait_for_drain();

    // Random part in three idling regimes; drain fully between regimes
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin sender_idle_pct = 28; receiver_idle_pct = 56; end
        1:       begin sender_idle_pct = 56; receiver_idle_pct = 28; end
        default: begin sender_idle_pct = 0;  receiver_idle_pct = 0;  end
      endcase
      phase_start = sent_items;
      while (sent_items - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(9);
        if (shadow_first_cnt > 24 || pick == 9) begin
          // Empty the first list so later runs start clean
          while (shadow_first_cnt != 0) delete_valid();
          send_op(slsm_pkg::OP_MERGE, $urandom, slsm_pkg::POS_W'($urandom_range(63)));
        end else if (pick < 6) begin
          // Well-formed: ascending appends, merge, a few deletes, merge again
          append_run(1'b0, $urandom_range(0, 6));
          append_run(1'b1, $urandom_range(0, 2));
          send_op(slsm_pkg::OP_MERGE, $urandom, slsm_pkg::POS_W'($urandom_range(63)));
          n = $urandom_range(0, 3);
          for (rep = 0; rep < n; rep++) begin
            if (shadow_first_cnt != 0 && $urandom_range(4) != 0) delete_valid();
            else send_op(slsm_pkg::OP_DELETE, $urandom, slsm_pkg::POS_W'($urandom_range(63)));
          end
          send_op(slsm_pkg::OP_MERGE, $urandom, slsm_pkg::POS_W'($urandom_range(63)));
        end else if (pick < 8) begin
          // Noise: any operation with any field contents
          for (rep = 0; rep < 8; rep++)
            send_op(slsm_pkg::op_e'($urandom_range(3)), $urandom,
                    slsm_pkg::POS_W'($urandom_range(63)));
        end else begin
          // Fill the first list past capacity, then merge the full store
          append_run(1'b0, LIST_DEPTH - shadow_first_cnt + $urandom_range(1, 2));
          send_op(slsm_pkg::OP_MERGE, $urandom, slsm_pkg::POS_W'($urandom_range(63)));
        end
      end
      wait_for_drain();
    end

    in_valid_i <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (100) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
